// ===== rtl/core/assert_macros.svh =====
// assertion helpers, sampled on clk and disabled during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/core/mcr_pkg.sv =====
`default_nettype none
package mcr_pkg;
  localparam int COORD_BITS  = 16;
  localparam int RADIUS_BITS = 11;
  localparam int COLOR_W     = 24;
  localparam int OUT_W       = COORD_BITS + 1;
  localparam int POS_W       = RADIUS_BITS + 1;
  localparam int STEP_W      = RADIUS_BITS + 2;
  localparam int ERR_W       = RADIUS_BITS + 4;
  localparam int SUM_W       = ((COORD_BITS > POS_W) ? COORD_BITS : POS_W) + 2;
  localparam int IDX_W       = 4;

  localparam logic [IDX_W-1:0] IDX_FIRST_SPAN  = IDX_W'(0);
  localparam logic [IDX_W-1:0] IDX_FIRST_PIXEL = IDX_W'(4);
  localparam logic [IDX_W-1:0] IDX_LAST        = IDX_W'(11);

  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } opcode_t;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_SPAN  = 1'b1
  } kind_t;

  // everything one step needs to produce its results
  typedef struct packed {
    logic signed [COORD_BITS-1:0] x0;
    logic signed [COORD_BITS-1:0] y0;
    logic signed [POS_W-1:0]      x;
    logic signed [POS_W-1:0]      y;
    logic [COLOR_W-1:0]           stroke;
    logic [COLOR_W-1:0]           fill;
    logic                         fill_on;
    logic                         done;
  } step_t;

  typedef struct packed {
    logic busy;
    logic ready;
  } emit_status_t;
endpackage
`default_nettype wire

// ===== rtl/core/mcr_walker.sv =====
`default_nettype none
module mcr_walker (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  fire,
  input  wire logic                                  opcode,
  input  wire logic signed [mcr_pkg::COORD_BITS-1:0] center_x,
  input  wire logic signed [mcr_pkg::COORD_BITS-1:0] center_y,
  input  wire logic [mcr_pkg::RADIUS_BITS-1:0]       radius,
  input  wire logic [mcr_pkg::COLOR_W-1:0]           stroke_rgb,
  input  wire logic [mcr_pkg::COLOR_W-1:0]           fill_rgb,
  input  wire logic                                  fill_enable,
  output logic                                       step_push,
  output mcr_pkg::step_t                             step
);
  import mcr_pkg::*;

  logic signed [COORD_BITS-1:0] ctr_x;
  logic signed [COORD_BITS-1:0] ctr_y;
  logic [RADIUS_BITS-1:0]       rad;
  logic [COLOR_W-1:0]           stroke_reg;
  logic [COLOR_W-1:0]           fill_reg;
  logic                         fill_on;
  logic signed [POS_W-1:0]      cur_x;
  logic signed [POS_W-1:0]      cur_y;
  logic [STEP_W-1:0]            step_dx;
  logic [STEP_W-1:0]            step_dy;
  logic signed [ERR_W-1:0]      err_acc;

  logic                         idle;
  logic signed [ERR_W-1:0]      twice_rad;
  logic signed [ERR_W-1:0]      err_mid;
  logic signed [POS_W-1:0]      cur_y_next;
  logic [STEP_W-1:0]            step_dy_next;
  logic signed [POS_W-1:0]      cur_x_next;
  logic [STEP_W-1:0]            step_dx_next;
  logic signed [ERR_W-1:0]      err_acc_next;

  assign idle      = cur_x < cur_y;
  assign twice_rad = signed'(ERR_W'({rad, 1'b0}));

  // y move first, then the x move looks at the updated error
  always_comb begin
    err_mid      = err_acc;
    cur_y_next   = cur_y;
    step_dy_next = step_dy;
    if (err_acc <= 0) begin
      cur_y_next   = cur_y + POS_W'(1);
      err_mid      = err_acc + ERR_W'(signed'({1'b0, step_dy}));
      step_dy_next = step_dy + STEP_W'(2);
    end
    err_acc_next = err_mid;
    cur_x_next   = cur_x;
    step_dx_next = step_dx;
    if (err_mid > 0) begin
      cur_x_next   = cur_x - POS_W'(1);
      step_dx_next = step_dx + STEP_W'(2);
      err_acc_next = err_mid + ERR_W'(signed'({1'b0, step_dx + STEP_W'(2)})) - twice_rad;
    end
  end

  assign step_push = fire && (opcode == OP_ADVANCE) && !idle;

  always_comb begin
    step.x0      = ctr_x;
    step.y0      = ctr_y;
    step.x       = cur_x;
    step.y       = cur_y;
    step.stroke  = stroke_reg;
    step.fill    = fill_reg;
    step.fill_on = fill_on;
    step.done    = cur_x_next < cur_y_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctr_x      <= '0;
      ctr_y      <= '0;
      rad        <= '0;
      stroke_reg <= '0;
      fill_reg   <= '0;
      fill_on    <= 1'b0;
      cur_x      <= '1;
      cur_y      <= '0;
      step_dx    <= STEP_W'(1);
      step_dy    <= STEP_W'(1);
      err_acc    <= '0;
    end else if (fire && (opcode == OP_START)) begin
      ctr_x      <= center_x;
      ctr_y      <= center_y;
      rad        <= radius;
      stroke_reg <= stroke_rgb;
      fill_reg   <= fill_rgb;
      fill_on    <= fill_enable;
      cur_x      <= signed'({1'b0, radius}) - POS_W'(1);
      cur_y      <= '0;
      step_dx    <= STEP_W'(1);
      step_dy    <= STEP_W'(1);
      err_acc    <= ERR_W'(1) - ERR_W'({radius, 1'b0});
    end else if (step_push) begin
      cur_x   <= cur_x_next;
      cur_y   <= cur_y_next;
      step_dx <= step_dx_next;
      step_dy <= step_dy_next;
      err_acc <= err_acc_next;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/mcr_emitter.sv =====
`default_nettype none
module mcr_emitter (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             step_push,
  input  wire mcr_pkg::step_t                   step,
  output mcr_pkg::emit_status_t                 status,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  kind,
  output logic signed [mcr_pkg::OUT_W-1:0]      x_start,
  output logic signed [mcr_pkg::OUT_W-1:0]      x_end,
  output logic signed [mcr_pkg::OUT_W-1:0]      y_pos,
  output logic [mcr_pkg::COLOR_W-1:0]           color,
  output logic                                  last,
  output logic                                  done_res
);
  import mcr_pkg::*;

  step_t             snap;
  logic              busy;
  logic [IDX_W-1:0]  idx;
  logic              load;

  logic signed [SUM_W-1:0] x0e, y0e, xe, ye;
  logic signed [SUM_W-1:0] xs_w, xe_w, yp_w;
  logic                    is_span;

  assign load         = busy && (!out_valid || out_ready);
  assign status.busy  = busy;
  assign status.ready = !busy || (load && (idx == IDX_LAST));

  assign x0e = SUM_W'(snap.x0);
  assign y0e = SUM_W'(snap.y0);
  assign xe  = SUM_W'(snap.x);
  assign ye  = SUM_W'(snap.y);

  // spans first (only when fill is on), then the eight octant pixels
  always_comb begin
    is_span = idx < IDX_FIRST_PIXEL;
    xs_w    = x0e + xe;
    xe_w    = x0e + xe;
    yp_w    = y0e + ye;
    case (idx)
      4'd0:    begin xs_w = x0e - ye; xe_w = x0e + ye; yp_w = y0e + xe; end
      4'd1:    begin xs_w = x0e - xe; xe_w = x0e + xe; yp_w = y0e + ye; end
      4'd2:    begin xs_w = x0e - ye; xe_w = x0e + ye; yp_w = y0e - xe; end
      4'd3:    begin xs_w = x0e - xe; xe_w = x0e + xe; yp_w = y0e - ye; end
      4'd4:    begin xs_w = x0e + xe; yp_w = y0e + ye; end
      4'd5:    begin xs_w = x0e + ye; yp_w = y0e + xe; end
      4'd6:    begin xs_w = x0e - ye; yp_w = y0e + xe; end
      4'd7:    begin xs_w = x0e - xe; yp_w = y0e + ye; end
      4'd8:    begin xs_w = x0e - xe; yp_w = y0e - ye; end
      4'd9:    begin xs_w = x0e - ye; yp_w = y0e - xe; end
      4'd10:   begin xs_w = x0e + ye; yp_w = y0e - xe; end
      default: begin xs_w = x0e + xe; yp_w = y0e - ye; end
    endcase
    if (!is_span) begin
      xe_w = xs_w + SUM_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      // a new step only arrives when idle or on the last load of the previous one
      if (step_push) begin
        busy <= 1'b1;
        snap <= step;
        idx  <= step.fill_on ? IDX_FIRST_SPAN : IDX_FIRST_PIXEL;
      end else if (load) begin
        if (idx == IDX_LAST) begin
          busy <= 1'b0;
        end else begin
          idx <= idx + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind     <= is_span ? KIND_SPAN : KIND_PIXEL;
      x_start  <= xs_w[OUT_W-1:0];
      x_end    <= xe_w[OUT_W-1:0];
      y_pos    <= yp_w[OUT_W-1:0];
      color    <= is_span ? snap.fill : snap.stroke;
      last     <= idx == IDX_LAST;
      done_res <= (idx == IDX_LAST) && snap.done;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/midpoint_circle_rasterizer.sv =====
// an accepted advance goes to the emitter's step snapshot; its results are registered
// from there when the output is free, 12 beats (8 with fill off), one per cycle on the
// single result port while out_ready holds; the next beat is taken while the last
// result of the previous step is going out
// reset: synchronous, active high; the walker goes idle and no result is pending
`default_nettype none
`include "assert_macros.svh"
module midpoint_circle_rasterizer (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic                                  opcode,
  input  wire logic signed [mcr_pkg::COORD_BITS-1:0] center_x,
  input  wire logic signed [mcr_pkg::COORD_BITS-1:0] center_y,
  input  wire logic [mcr_pkg::RADIUS_BITS-1:0]       radius,
  input  wire logic [mcr_pkg::COLOR_W-1:0]           stroke_rgb,
  input  wire logic [mcr_pkg::COLOR_W-1:0]           fill_rgb,
  input  wire logic                                  fill_enable,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic                                       kind,
  output logic signed [mcr_pkg::OUT_W-1:0]           x_start,
  output logic signed [mcr_pkg::OUT_W-1:0]           x_end,
  output logic signed [mcr_pkg::OUT_W-1:0]           y_pos,
  output logic [mcr_pkg::COLOR_W-1:0]                color,
  output logic                                       last,
  output logic                                       done_res
);
  import mcr_pkg::*;

  logic         fire;
  logic         step_push;
  step_t        step;
  emit_status_t emit_stat;

  assign in_ready = emit_stat.ready;
  assign fire     = in_valid && in_ready;

  mcr_walker u_walker (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .opcode     (opcode),
    .center_x   (center_x),
    .center_y   (center_y),
    .radius     (radius),
    .stroke_rgb (stroke_rgb),
    .fill_rgb   (fill_rgb),
    .fill_enable(fill_enable),
    .step_push  (step_push),
    .step       (step)
  );

  mcr_emitter u_emitter (
    .clk      (clk),
    .rst      (rst),
    .step_push(step_push),
    .step     (step),
    .status   (emit_stat),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind     (kind),
    .x_start  (x_start),
    .x_end    (x_end),
    .y_pos    (y_pos),
    .color    (color),
    .last     (last),
    .done_res (done_res)
  );

  `ASSERT_IMPL(a_done_on_last, out_valid && done_res, last)
  `ASSERT_NEXT(a_step_queued, step_push, emit_stat.busy)
  `ASSERT_IMPL(a_stall_only_busy, !in_ready, emit_stat.busy)
endmodule
`default_nettype wire
